@@ src/sfb_pkg.sv @@
package sfb_pkg;

	localparam int unsigned COORD_W         = 12;
	localparam int unsigned RATIO_BITS_DEF  = 16;
	localparam int unsigned CFG_IDX_W       = 3;

	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_LEFT   = 3'd0,
		REG_SRC_RIGHT  = 3'd1,
		REG_SRC_TOP    = 3'd2,
		REG_SRC_BOTTOM = 3'd3,
		REG_DST_LEFT   = 3'd4,
		REG_DST_RIGHT  = 3'd5,
		REG_DST_TOP    = 3'd6,
		REG_DST_BOTTOM = 3'd7
	} reg_idx_t;

	typedef struct packed {
		coord_t src_left;
		coord_t src_right;
		coord_t src_top;
		coord_t src_bottom;
		coord_t dst_left;
		coord_t dst_right;
		coord_t dst_top;
		coord_t dst_bottom;
	} geom_t;

	typedef struct packed {
		coord_t sw;
		coord_t sh;
		coord_t dw;
		coord_t dh;
	} ext_t;

	function automatic coord_t extent(input coord_t a, input coord_t b);
		return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
	endfunction

	// mirrored axis counts down from the first edge
	function automatic coord_t place(input coord_t first, input coord_t second,
		input coord_t off);
		return (first > second) ? coord_t'(first - off - coord_t'(1)) :
			coord_t'(first + off);
	endfunction

endpackage

@@ src/sfb_divider.sv @@
module sfb_divider #(
	parameter int unsigned RATIO_BITS = sfb_pkg::RATIO_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  sfb_pkg::coord_t                        num,
	input  sfb_pkg::coord_t                        den,
	output logic                                   busy,
	output logic [sfb_pkg::COORD_W+RATIO_BITS-1:0] ratio
);

	localparam int unsigned NW = sfb_pkg::COORD_W + RATIO_BITS;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0]                 acc_q;
	sfb_pkg::coord_t               rem_q;
	logic [CW-1:0]                 cnt_q;
	logic                          busy_q;
	logic [NW-1:0]                 ratio_q;
	logic [sfb_pkg::COORD_W:0]     rem_sh;
	logic                          ge;
	logic [sfb_pkg::COORD_W:0]     rem_n;
	logic [NW-1:0]                 acc_n;

	assign rem_sh = {rem_q, acc_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den};
	assign rem_n  = ge ? (rem_sh - {1'b0, den}) : rem_sh;
	assign acc_n  = {acc_q[NW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {num, {RATIO_BITS{1'b0}}};
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_n;
			rem_q <= rem_n[sfb_pkg::COORD_W-1:0];
			if (cnt_q == CW'(1)) begin
				ratio_q <= acc_n + NW'(1);
			end
		end
	end

	assign busy  = busy_q;
	assign ratio = ratio_q;

endmodule

@@ src/sfb_pipe.sv @@
module sfb_pipe #(
	parameter int unsigned RATIO_BITS = sfb_pkg::RATIO_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sfb_pkg::geom_t                         geom,
	input  sfb_pkg::ext_t                          ext,
	input  logic [sfb_pkg::COORD_W+RATIO_BITS-1:0] ratio_x,
	input  logic [sfb_pkg::COORD_W+RATIO_BITS-1:0] ratio_y,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  sfb_pkg::coord_t                        col_offset,
	input  sfb_pkg::coord_t                        row_offset,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output sfb_pkg::coord_t                        dest_x,
	output sfb_pkg::coord_t                        dest_y,
	output sfb_pkg::coord_t                        source_x,
	output sfb_pkg::coord_t                        source_y,
	output logic                                   in_range
);

	localparam int unsigned CW = sfb_pkg::COORD_W;
	localparam int unsigned PW = 2 * CW + RATIO_BITS;

	logic            v_s1, v_s2, v_s3;
	logic            adv1, adv2, adv3;
	sfb_pkg::coord_t col_s1, row_s1, dx_s1, dy_s1;
	logic            rng_s1, rng_s2;
	sfb_pkg::coord_t dx_s2, dy_s2, scx_s2, scy_s2;
	sfb_pkg::coord_t dx_s3, dy_s3, sx_s3, sy_s3;
	logic            rng_s3;
	logic [PW-1:0]   prod_x, prod_y;

	assign adv3     = !v_s3 || !out_stall;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	assign prod_x = PW'(col_s1) * PW'(ratio_x);
	assign prod_y = PW'(row_s1) * PW'(ratio_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// s1: range check and destination placement
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			col_s1 <= col_offset;
			row_s1 <= row_offset;
			rng_s1 <= (col_offset < ext.dw) && (row_offset < ext.dh);
			dx_s1  <= sfb_pkg::place(geom.dst_left, geom.dst_right, col_offset);
			dy_s1  <= sfb_pkg::place(geom.dst_top, geom.dst_bottom, row_offset);
		end
	end

	// s2: scale offsets by the ratio
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			rng_s2 <= rng_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			scx_s2 <= prod_x[RATIO_BITS+CW-1:RATIO_BITS];
			scy_s2 <= prod_y[RATIO_BITS+CW-1:RATIO_BITS];
		end
	end

	// s3: source placement, zero when out of range
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			rng_s3 <= rng_s2;
			dx_s3  <= rng_s2 ? dx_s2 : '0;
			dy_s3  <= rng_s2 ? dy_s2 : '0;
			sx_s3  <= rng_s2 ? sfb_pkg::place(geom.src_left, geom.src_right, scx_s2) : '0;
			sy_s3  <= rng_s2 ? sfb_pkg::place(geom.src_top, geom.src_bottom, scy_s2) : '0;
		end
	end

	assign out_valid = v_s3;
	assign dest_x    = dx_s3;
	assign dest_y    = dy_s3;
	assign source_x  = sx_s3;
	assign source_y  = sy_s3;
	assign in_range  = rng_s3;

endmodule

@@ src/scaled_flip_blit_address_gen.sv @@
// Nearest-neighbor scaling blit address generator with per-axis mirroring.
// Each item is a destination offset (col_offset, row_offset); the result is
// the absolute destination and nearest source coordinate plus in_range.
// Throughput is one item per clock unless in_stall or out_stall holds it; the
// datapath pipeline stages are range/destination, ratio multiply, source place.
// The per-axis ratios come from two bit-serial restoring dividers: after
// reset and after every configuration write, in_stall stays high while both
// ratios are recomputed.
module scaled_flip_blit_address_gen #(
	parameter int unsigned RATIO_BITS = sfb_pkg::RATIO_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  sfb_pkg::coord_t               cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sfb_pkg::coord_t               col_offset,
	input  sfb_pkg::coord_t               row_offset,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sfb_pkg::coord_t               dest_x,
	output sfb_pkg::coord_t               dest_y,
	output sfb_pkg::coord_t               source_x,
	output sfb_pkg::coord_t               source_y,
	output logic                          in_range
);

	localparam int unsigned RW = sfb_pkg::COORD_W + RATIO_BITS;

	sfb_pkg::geom_t  geom_q;
	sfb_pkg::ext_t   ext_c, ext_q;
	logic            start_q;
	logic            busy_x, busy_y;
	logic [RW-1:0]   ratio_x, ratio_y;
	logic            pipe_ready;
	logic            cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q  <= '0;
			start_q <= 1'b1;
		end else begin
			start_q <= cfg_wr;
			if (cfg_wr) begin
				unique case (sfb_pkg::reg_idx_t'(cfg_index))
					sfb_pkg::REG_SRC_LEFT:   geom_q.src_left   <= cfg_data;
					sfb_pkg::REG_SRC_RIGHT:  geom_q.src_right  <= cfg_data;
					sfb_pkg::REG_SRC_TOP:    geom_q.src_top    <= cfg_data;
					sfb_pkg::REG_SRC_BOTTOM: geom_q.src_bottom <= cfg_data;
					sfb_pkg::REG_DST_LEFT:   geom_q.dst_left   <= cfg_data;
					sfb_pkg::REG_DST_RIGHT:  geom_q.dst_right  <= cfg_data;
					sfb_pkg::REG_DST_TOP:    geom_q.dst_top    <= cfg_data;
					sfb_pkg::REG_DST_BOTTOM: geom_q.dst_bottom <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		ext_c.sw = sfb_pkg::extent(geom_q.src_left, geom_q.src_right);
		ext_c.sh = sfb_pkg::extent(geom_q.src_top, geom_q.src_bottom);
		ext_c.dw = sfb_pkg::extent(geom_q.dst_left, geom_q.dst_right);
		ext_c.dh = sfb_pkg::extent(geom_q.dst_top, geom_q.dst_bottom);
	end

	always_ff @(posedge clk) begin
		ext_q <= ext_c;
	end

	sfb_divider #(.RATIO_BITS(RATIO_BITS)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (ext_c.sw),
		.den    (ext_c.dw),
		.busy   (busy_x),
		.ratio  (ratio_x)
	);

	sfb_divider #(.RATIO_BITS(RATIO_BITS)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (ext_c.sh),
		.den    (ext_c.dh),
		.busy   (busy_y),
		.ratio  (ratio_y)
	);

	sfb_pipe #(.RATIO_BITS(RATIO_BITS)) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom_q),
		.ext        (ext_q),
		.ratio_x    (ratio_x),
		.ratio_y    (ratio_y),
		.in_valid   (in_valid && !in_stall),
		.in_ready   (pipe_ready),
		.col_offset (col_offset),
		.row_offset (row_offset),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.source_x   (source_x),
		.source_y   (source_y),
		.in_range   (in_range)
	);

	assign in_stall = !pipe_ready || start_q || busy_x || busy_y;

endmodule

@@ src/sfb_checker.sv @@
module sfb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cfg_valid,
	input logic            cfg_ready,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input sfb_pkg::coord_t dest_x,
	input sfb_pkg::coord_t dest_y,
	input sfb_pkg::coord_t source_x,
	input sfb_pkg::coord_t source_y,
	input logic            in_range
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dest_x) && $stable(dest_y)
			&& $stable(source_x) && $stable(source_y) && $stable(in_range))
		else $error("stalled result changed");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> dest_x == '0 && dest_y == '0
			&& source_x == '0 && source_y == '0)
		else $error("out of range result not zero");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("item taken while ratio recomputes");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("item not delivered after three free cycles");

endmodule

bind scaled_flip_blit_address_gen sfb_checker u_sfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.dest_x    (dest_x),
	.dest_y    (dest_y),
	.source_x  (source_x),
	.source_y  (source_y),
	.in_range  (in_range)
);
